FILE: design/sc2asc_pkg.sv
// shared types, key codes and set-1 us layout character tables
package sc2asc_pkg;

	typedef enum logic {
		CMD_SCAN = 1'b0,
		CMD_READ = 1'b1
	} cmd_e;

	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;

	typedef struct packed {
		logic       command;
		logic [7:0] scancode;
	} item_t;

	typedef struct packed {
		logic [6:0] read_char;
		logic       chars_pending;
		logic       dropped;
	} result_t;

	// character request from the translator to the buffer
	typedef struct packed {
		logic       push;
		logic [6:0] ch;
	} push_req_t;

	// per-item buffer status towards the result register
	typedef struct packed {
		logic pop;
		logic drop;
		logic pending;
	} fifo_stat_t;

	function automatic logic [6:0] plain_char(input logic [6:0] code);
		logic [6:0] c;
		unique case (code)
			7'h01: c = 7'h1B;
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h4A: c = 7'h2D;
			7'h4E: c = 7'h2B;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] shift_char(input logic [6:0] code);
		logic [6:0] p;
		logic [6:0] c;
		p = plain_char(code);
		unique case (code)
			7'h02: c = 7'h21;
			7'h03: c = 7'h40;
			7'h04: c = 7'h23;
			7'h05: c = 7'h24;
			7'h06: c = 7'h25;
			7'h07: c = 7'h5E;
			7'h08: c = 7'h26;
			7'h09: c = 7'h2A;
			7'h0A: c = 7'h28;
			7'h0B: c = 7'h29;
			7'h0C: c = 7'h5F;
			7'h0D: c = 7'h2B;
			7'h1A: c = 7'h7B;
			7'h1B: c = 7'h7D;
			7'h27: c = 7'h3A;
			7'h28: c = 7'h22;
			7'h29: c = 7'h7E;
			7'h2B: c = 7'h7C;
			7'h33: c = 7'h3C;
			7'h34: c = 7'h3E;
			7'h35: c = 7'h3F;
			default: begin
				// letters go to upper case, the rest are the same as unshifted
				if (p >= 7'h61 && p <= 7'h7A) begin
					c = p - 7'h20;
				end else begin
					c = p;
				end
			end
		endcase
		return c;
	endfunction

endpackage

FILE: design/scancode_to_ascii_fifo.sv
// top level: set-1 scancode translator with character buffer
// Each item is either a keyboard scancode or a read request and yields exactly
// one result in the next cycle. The block takes one item per clock: translation,
// the buffer pointer update and the buffer write or read all happen at the
// accepting edge, and the result register (with the registered buffer read
// port) holds the answer until the downstream side takes it. While a result
// waits, a new item is still taken as long as the result is taken in the same
// cycle. The buffer holds at most BUFFER_DEPTH-1 characters; a character that
// finds it full is lost and flagged with dropped. Reads from an empty buffer
// return zero. Buffer contents need no clearing after reset.
module scancode_to_ascii_fifo #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  sc2asc_pkg::item_t     item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output sc2asc_pkg::result_t   result
);
	import sc2asc_pkg::*;

	logic       accept;
	push_req_t  req;
	fifo_stat_t stat;
	logic [6:0] rd_data_q;
	logic       valid_s1;
	logic       pop_s1;
	logic       pending_s1;
	logic       dropped_s1;

	// the result slot frees up in the same cycle it is taken
	assign item_ready = !valid_s1 || result_ready;
	assign accept     = item_valid && item_ready;

	// shift state and table lookup
	sc2asc_xlate u_xlate (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.req    (req)
	);

	// ring buffer with registered read data
	sc2asc_fifo #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rd_req    (item.command == CMD_READ),
		.req       (req),
		.stat      (stat),
		.rd_data_q (rd_data_q)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1     <= stat.pop;
			pending_s1 <= stat.pending;
			dropped_s1 <= stat.drop;
		end
	end

	assign result_valid = valid_s1;

	always_comb begin
		// read data only counts when an item really popped a character
		result.read_char     = pop_s1 ? rd_data_q : 7'h00;
		result.chars_pending = pending_s1;
		result.dropped       = dropped_s1;
	end

endmodule

FILE: design/sc2asc_xlate.sv
// shift tracking and scancode to character lookup
module sc2asc_xlate (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  sc2asc_pkg::item_t       item,
	output sc2asc_pkg::push_req_t   req
);
	import sc2asc_pkg::*;

	logic       shift_q;
	logic       is_scan;
	logic       is_release;
	logic       is_shift_key;
	logic [6:0] key;
	logic [6:0] ch;

	assign is_scan      = (item.command == CMD_SCAN);
	assign is_release   = item.scancode[7];
	assign key          = item.scancode[6:0];
	assign is_shift_key = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
	assign ch           = shift_q ? shift_char(key) : plain_char(key);

	always_comb begin
		req.ch   = ch;
		req.push = is_scan && !is_release && !is_shift_key && (ch != 7'h00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
		end else if (accept && is_scan && is_shift_key) begin
			// press sets, release clears
			shift_q <= !is_release;
		end
	end

endmodule

FILE: design/sc2asc_fifo.sv
// character ring buffer, one slot always kept free
module sc2asc_fifo #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     rd_req,
	input  sc2asc_pkg::push_req_t    req,
	output sc2asc_pkg::fifo_stat_t   stat,
	output logic [6:0]               rd_data_q
);
	import sc2asc_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

	logic [6:0]    mem [BUFFER_DEPTH];
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_inc;
	logic [AW-1:0] wr_inc;
	logic [AW-1:0] rd_nxt;
	logic [AW-1:0] wr_nxt;
	logic          empty;
	logic          full;
	logic          pop;
	logic          push;

	assign rd_inc = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign wr_inc = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign empty  = (rd_ptr_q == wr_ptr_q);
	assign full   = (wr_inc == rd_ptr_q);
	assign pop    = rd_req && !empty;
	assign push   = req.push && !full;
	assign rd_nxt = pop ? rd_inc : rd_ptr_q;
	assign wr_nxt = push ? wr_inc : wr_ptr_q;

	always_comb begin
		stat.pop     = pop;
		stat.drop    = req.push && full;
		stat.pending = (rd_nxt != wr_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else if (accept) begin
			rd_ptr_q <= rd_nxt;
			wr_ptr_q <= wr_nxt;
		end
	end

	// a pop never hits the slot being written, so old-data read is safe
	always_ff @(posedge clk) begin
		if (accept && push) begin
			mem[wr_ptr_q] <= req.ch;
		end
		if (accept && pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

endmodule

FILE: verif/tb_scancode_to_ascii_fifo.sv
`timescale 1ns / 1ps
// testbench for the set-1 scancode translator and its character buffer
module tb_scancode_to_ascii_fifo;
	import sc2asc_pkg::*;

	localparam int DEPTH = 256;
	// quiet tail after the last owed result arrives, before the verdict
	localparam int TAIL_CYCLES = 8;
	// cycles without any handshake before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// random items sent after the directed table
	localparam int RANDOM_ITEMS = 1700;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICTED = 1'b0;
	localparam result_t QUIET = '0;

	// shape of the random traffic, one kind per phase
	typedef enum int {
		PH_TYPING,
		PH_DRAIN,
		PH_MIXED,
		PH_NOISE,
		PH_FLOOD
	} phase_e;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} row_t;

	// an expected result and the number of the item that owes it
	typedef struct {
		int      seq;
		result_t value;
	} owed_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// translator state as the testbench sees it
	logic       caps_model;
	logic [6:0] char_ring [DEPTH];
	int         rd_idx;
	int         wr_idx;

	owed_t owed_results [$];
	owed_t checked;
	int    mismatch_count = 0;
	int    items_sent = 0;
	int    quiet_cycles = 0;
	bit    gaps_on = 1'b1;

	// receiver stall state
	int ready_hold = 0;
	int ready_calm = 0;
	int ready_roll;

	// directed part: extremes first, then shift handling, then drain to empty
	row_t directed_rows [23] = '{
		'{'{CMD_READ, 8'h00}, TYPED, '{7'h00, 1'b0, 1'b0}},     // read with nothing stored
		'{'{CMD_SCAN, 8'h00}, TYPED, '{7'h00, 1'b0, 1'b0}},     // lowest code, unmapped
		'{'{CMD_SCAN, 8'h7F}, TYPED, '{7'h00, 1'b0, 1'b0}},     // highest press, unmapped
		'{'{CMD_SCAN, 8'hFF}, TYPED, '{7'h00, 1'b0, 1'b0}},     // highest release
		'{'{CMD_SCAN, 8'hE0}, TYPED, '{7'h00, 1'b0, 1'b0}},     // extended prefix
		'{'{CMD_SCAN, 8'hE1}, TYPED, '{7'h00, 1'b0, 1'b0}},     // pause prefix
		'{'{CMD_SCAN, 8'h1E}, TYPED, '{7'h00, 1'b1, 1'b0}},     // plain 'a' goes in
		'{'{CMD_READ, 8'h00}, TYPED, '{7'h61, 1'b0, 1'b0}},     // and comes back out
		'{'{CMD_SCAN, 8'h2A}, TYPED, '{7'h00, 1'b0, 1'b0}},     // left shift down
		'{'{CMD_SCAN, 8'h1E}, PREDICTED, QUIET},
		'{'{CMD_SCAN, 8'h02}, PREDICTED, QUIET},
		'{'{CMD_SCAN, 8'hAA}, TYPED, '{7'h00, 1'b1, 1'b0}},     // left shift up
		'{'{CMD_SCAN, 8'h36}, PREDICTED, QUIET},                // right shift down
		'{'{CMD_SCAN, 8'h28}, PREDICTED, QUIET},
		'{'{CMD_SCAN, 8'hB6}, PREDICTED, QUIET},                // right shift up
		'{'{CMD_SCAN, 8'h02}, PREDICTED, QUIET},
		'{'{CMD_SCAN, 8'h01}, PREDICTED, QUIET},
		'{'{CMD_READ, 8'h5A}, PREDICTED, QUIET},                // scancode ignored on reads
		'{'{CMD_READ, 8'h80}, PREDICTED, QUIET},
		'{'{CMD_READ, 8'h3C}, PREDICTED, QUIET},
		'{'{CMD_READ, 8'hC3}, PREDICTED, QUIET},
		'{'{CMD_READ, 8'h7F}, PREDICTED, QUIET},
		'{'{CMD_READ, 8'hFF}, TYPED, '{7'h00, 1'b0, 1'b0}}      // empty again
	};

	scancode_to_ascii_fifo #(
		.BUFFER_DEPTH(DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// us layout: high byte unshifted, low byte shifted; zero for keys with no character
	function automatic logic [6:0] ascii_of(input logic [6:0] code, input logic upper);
		logic [15:0] pair;
		case (code)
			7'h01: pair = {8'h1B, 8'h1B};
			7'h02: pair = "1!";
			7'h03: pair = "2@";
			7'h04: pair = "3#";
			7'h05: pair = "4$";
			7'h06: pair = "5%";
			7'h07: pair = "6^";
			7'h08: pair = "7&";
			7'h09: pair = "8*";
			7'h0A: pair = "9(";
			7'h0B: pair = "0)";
			7'h0C: pair = "-_";
			7'h0D: pair = "=+";
			7'h0E: pair = {8'h08, 8'h08};
			7'h0F: pair = {8'h09, 8'h09};
			7'h10: pair = "qQ";
			7'h11: pair = "wW";
			7'h12: pair = "eE";
			7'h13: pair = "rR";
			7'h14: pair = "tT";
			7'h15: pair = "yY";
			7'h16: pair = "uU";
			7'h17: pair = "iI";
			7'h18: pair = "oO";
			7'h19: pair = "pP";
			7'h1A: pair = "[{";
			7'h1B: pair = "]}";
			7'h1C: pair = {8'h0A, 8'h0A};
			7'h1E: pair = "aA";
			7'h1F: pair = "sS";
			7'h20: pair = "dD";
			7'h21: pair = "fF";
			7'h22: pair = "gG";
			7'h23: pair = "hH";
			7'h24: pair = "jJ";
			7'h25: pair = "kK";
			7'h26: pair = "lL";
			7'h27: pair = ";:";
			7'h28: pair = "'\"";
			7'h29: pair = "`~";
			7'h2B: pair = "\\|";
			7'h2C: pair = "zZ";
			7'h2D: pair = "xX";
			7'h2E: pair = "cC";
			7'h2F: pair = "vV";
			7'h30: pair = "bB";
			7'h31: pair = "nN";
			7'h32: pair = "mM";
			7'h33: pair = ",<";
			7'h34: pair = ".>";
			7'h35: pair = "/?";
			7'h37: pair = "**";
			7'h39: pair = "  ";
			7'h4A: pair = "--";
			7'h4E: pair = "++";
			default: pair = 16'h0000;
		endcase
		return upper ? pair[6:0] : pair[14:8];
	endfunction

	// advances the translator state by one item and returns what it should answer
	function automatic result_t translate_step(input item_t it);
		result_t    r;
		logic [6:0] ch;
		int         nxt;
		r = '0;
		if (it.command == CMD_READ) begin
			if (rd_idx != wr_idx) begin
				r.read_char = char_ring[rd_idx];
				rd_idx = (rd_idx + 1) % DEPTH;
			end
		end else if (it.scancode[7]) begin
			// only the two shift releases matter, prefixes fall through here too
			if (it.scancode[6:0] == KEY_LSHIFT || it.scancode[6:0] == KEY_RSHIFT) begin
				caps_model = 1'b0;
			end
		end else if (it.scancode[6:0] == KEY_LSHIFT || it.scancode[6:0] == KEY_RSHIFT) begin
			caps_model = 1'b1;
		end else begin
			ch = ascii_of(it.scancode[6:0], caps_model);
			if (ch != 7'h00) begin
				// one slot always stays free, so a full buffer loses the character
				nxt = (wr_idx + 1) % DEPTH;
				if (nxt != rd_idx) begin
					char_ring[wr_idx] = ch;
					wr_idx = nxt;
				end else begin
					r.dropped = 1'b1;
				end
			end
		end
		r.chars_pending = (rd_idx != wr_idx);
		return r;
	endfunction

	function automatic item_t random_item(input phase_e kind);
		item_t it;
		int    roll;
		roll = $urandom_range(0, 99);
		it.command = CMD_SCAN;
		// mostly presses in the mapped part of the table
		it.scancode = 8'($urandom_range(1, 8'h39));
		case (kind)
			PH_TYPING: begin
				if (roll < 10) begin
					it.command = CMD_READ;
					it.scancode = 8'($urandom);
				end else if (roll < 20) begin
					it.scancode = {1'($urandom_range(0, 1)),
						($urandom_range(0, 1) != 0) ? KEY_LSHIFT : KEY_RSHIFT};
				end else if (roll >= 94) begin
					it.scancode = 8'($urandom);
				end
			end
			PH_DRAIN: begin
				if (roll < 80) begin
					it.command = CMD_READ;
					it.scancode = 8'($urandom);
				end
			end
			PH_MIXED: begin
				if (roll < 45) begin
					it.command = CMD_READ;
					it.scancode = 8'($urandom);
				end else if (roll < 55) begin
					it.scancode = {1'($urandom_range(0, 1)),
						($urandom_range(0, 1) != 0) ? KEY_LSHIFT : KEY_RSHIFT};
				end else if (roll >= 90) begin
					it.scancode = 8'($urandom);
				end
			end
			PH_NOISE: begin
				it.command = 1'($urandom_range(0, 1));
				it.scancode = 8'($urandom);
			end
			default: begin
				// flood: presses only, with the odd shift change, to overrun the buffer
				if (roll < 8) begin
					it.scancode = {1'($urandom_range(0, 1)),
						($urandom_range(0, 1) != 0) ? KEY_LSHIFT : KEY_RSHIFT};
				end
			end
		endcase
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// offers one item, waits for it to be taken and records what it should produce
	task automatic send_key_item(input item_t it, input logic typed, input result_t typed_res);
		int      gap;
		int      roll;
		result_t predicted;
		owed_t   entry;
		gap = 0;
		if (gaps_on) begin
			roll = $urandom_range(0, 99);
			if (roll >= 92) begin
				gap = $urandom_range(8, 40);
			end else if (roll >= 60) begin
				gap = $urandom_range(1, 3);
			end
		end
		// valid only drops when a gap follows, so it is never lowered and raised in one step
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predicted = translate_step(it);
		entry.seq = items_sent;
		entry.value = typed ? typed_res : predicted;
		owed_results.push_back(entry);
		items_sent++;
	endtask

	// receiver: ready mostly high, short and long stalls, and calm stretches without any
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			result_ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			result_ready <= 1'b1;
			if (ready_calm > 0) begin
				ready_calm <= ready_calm - 1;
			end else begin
				ready_roll = $urandom_range(0, 99);
				if (ready_roll < 2) begin
					ready_calm <= $urandom_range(50, 300);
				end else if (ready_roll < 5) begin
					ready_hold <= $urandom_range(8, 30);
				end else if (ready_roll < 35) begin
					ready_hold <= $urandom_range(1, 3);
				end
			end
		end
	end

	// result checker and handshake activity for the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (result_valid && result_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result %h with no item owing one", result));
				end else begin
					checked = owed_results.pop_front();
					if (result.read_char != checked.value.read_char) begin
						report_mismatch($sformatf("item %0d read_char %h, want %h",
							checked.seq, result.read_char, checked.value.read_char));
					end
					if (result.chars_pending != checked.value.chars_pending) begin
						report_mismatch($sformatf("item %0d chars_pending %b, want %b",
							checked.seq, result.chars_pending, checked.value.chars_pending));
					end
					if (result.dropped != checked.value.dropped) begin
						report_mismatch($sformatf("item %0d dropped %b, want %b",
							checked.seq, result.dropped, checked.value.dropped));
					end
				end
			end
		end
	end

	// watchdog: a long stretch with no handshake at all means the block hung
	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		item_t  it;
		phase_e kind;
		int     len;
		int     phase;
		int     rand_sent;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		caps_model = 1'b0;
		rd_idx = 0;
		wr_idx = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < $size(directed_rows); r++) begin
			send_key_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
		end

		// random phases; every sixth one floods the buffer past full
		phase = 0;
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			if (phase % 6 == 1) begin
				kind = PH_FLOOD;
			end else begin
				kind = phase_e'($urandom_range(0, 3));
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			case (kind)
				PH_FLOOD: len = 300;
				PH_DRAIN: len = $urandom_range(40, 280);
				PH_NOISE: len = $urandom_range(10, 40);
				default: len = $urandom_range(30, 120);
			endcase
			for (int k = 0; k < len && rand_sent < RANDOM_ITEMS; k++) begin
				it = random_item(kind);
				send_key_item(it, PREDICTED, QUIET);
				rand_sent++;
			end
			phase++;
		end
		item_valid <= 1'b0;

		// let every owed result arrive, then watch a little longer for strays
		while (owed_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
